// File: design/dcfr_pkg.sv
// ----------------------------------------------------------------------------
// dcfr_pkg: shared definitions of the daisy-chain frame repeater
// Frame constants, route codes, parser and sender states, and the frame
// descriptor that travels from the parser to the sender.
// ----------------------------------------------------------------------------
package dcfr_pkg;

  // Default payload capacity of one frame.
  localparam int MAX_PAYLOAD_DEF = 56;

  // Width of the length and payload index fields.
  localparam int LEN_W = 6;

  // Frame constants.
  localparam logic [7:0]  SYNC_BYTE     = 8'hCA;
  localparam logic [15:0] SUM_SEED      = 16'h00CA;
  localparam logic [7:0]  NODE_TX_CMD   = 8'hAA;
  localparam logic [15:0] NODE_TX_EP    = 16'hFFFE;
  localparam logic [15:0] BCAST_EP      = 16'hFFFF;
  localparam logic [15:0] LOCAL_EP      = 16'h0000;
  localparam logic [7:0]  PIXEL_CMD     = 8'h47;
  localparam logic [7:0]  PIXEL_CMD_LUT = 8'h48;

  // Route codes.
  localparam logic [1:0] ROUTE_BCAST = 2'd0;
  localparam logic [1:0] ROUTE_LOCAL = 2'd1;
  localparam logic [1:0] ROUTE_PASS  = 2'd2;

  // Receive parser states.
  typedef enum logic [3:0] {
    P_SYNC,
    P_DLEN,
    P_CLEN,
    P_CMD,
    P_PAY,
    P_EPH,
    P_EPL,
    P_SUMH,
    P_SUML
  } p_state_t;

  // Transmit sender states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_PIX,
    B_SYNC,
    B_DLEN,
    B_CLEN,
    B_CMD,
    B_PRD,
    B_PDAT,
    B_EPH,
    B_EPL,
    B_SUMH,
    B_SUML
  } b_state_t;

  // Everything the sender needs to rebuild one outgoing frame.
  typedef struct packed {
    logic [1:0]       route;
    logic [7:0]       cmd;
    logic [7:0]       cmd_out;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] clen_out;
    logic [15:0]      endp_out;
    logic             pix_en;
    logic [LEN_W-1:0] pix_addr;
    logic [2:0]       pix_sel;
  } desc_t;

endpackage

// File: design/daisy_chain_frame_repeater_unit.sv
// Throughput: one received byte per cycle while a queue slot is free; the sender
// reads the pixel byte, sends the header, then fetches and sends each payload byte
// in turn (one payload memory read port), and sends every other byte directly.
// Reset: synchronous; clears the parser, the sender, the queue and the output valid.
// ----------------------------------------------------------------------------
// daisy_chain_frame_repeater_unit: daisy-chain frame repeater top level
// Receive parser, two-slot frame queue with payload banks, and transmit
// sender that rebuilds each good frame for the next node.
// ----------------------------------------------------------------------------
module daisy_chain_frame_repeater_unit #(
  parameter int MAX_PAYLOAD = dcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       tx_valid,
  input  logic       tx_ready,
  output logic [7:0] tx_byte,
  output logic       last_byte,
  output logic [1:0] route,
  output logic [7:0] command_code,
  output logic       pixel_bit
);
  import dcfr_pkg::*;

  logic             push;
  desc_t            push_desc;
  logic             q_full;
  logic             pop;
  logic             q_empty;
  desc_t            head;
  logic             wr_en;
  logic [LEN_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [LEN_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  // Receive parser.
  dcfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_desc(push_desc),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data)
  );

  // Frame queue and payload banks.
  dcfr_buffer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_buffer (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data)
  );

  // Transmit sender.
  dcfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .rd_en       (rd_en),
    .rd_idx      (rd_idx),
    .rd_data     (rd_data),
    .tx_valid    (tx_valid),
    .tx_ready    (tx_ready),
    .tx_byte     (tx_byte),
    .last_byte   (last_byte),
    .route       (route),
    .command_code(command_code),
    .pixel_bit   (pixel_bit)
  );

`ifndef ASSERT_OFF
  // A frame is queued only into a free slot.
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("frame pushed into a full queue");

  // The sender releases only a frame it holds.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("frame popped from an empty queue");

  // Payload is never written into a bank still owned by a queued frame.
  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !q_full)
    else $error("payload write while both banks are in use");

  // The final byte of a frame is loaded into the output register as its slot is released.
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    pop |=> (tx_valid && last_byte))
    else $error("slot released without a final byte");
`endif

endmodule

// File: design/dcfr_front.sv
// ----------------------------------------------------------------------------
// dcfr_front: receive parser
// Parses incoming link bytes, checks lengths and checksum, stores the
// payload and pushes a classified frame descriptor for each good frame.
// ----------------------------------------------------------------------------
module dcfr_front #(
  parameter int MAX_PAYLOAD = dcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  output logic                      rx_ready,
  input  logic [7:0]                rx_byte,
  input  logic                      q_full,
  output logic                      push,
  output dcfr_pkg::desc_t           push_desc,
  output logic                      wr_en,
  output logic [dcfr_pkg::LEN_W-1:0] wr_idx,
  output logic [7:0]                wr_data
);
  import dcfr_pkg::*;

  p_state_t         state, state_next;
  logic [LEN_W-1:0] dlen, dlen_next;
  logic [LEN_W-1:0] clen, clen_next;
  logic [7:0]       cmd, cmd_next;
  logic [LEN_W-1:0] pidx, pidx_next;
  logic [15:0]      rsum, rsum_next;
  logic [15:0]      ep, ep_next;
  logic [7:0]       sumh, sumh_next;
  logic             acc;
  logic [15:0]      rsum_add;
  logic [LEN_W-1:0] pidx_inc;
  logic [15:0]      pix_pos;
  logic [12:0]      pix_byte;
  logic             pix_cmd;

  // Requests are taken only while a buffer bank is free.
  assign rx_ready = !q_full;
  assign acc      = rx_valid && rx_ready;
  assign rsum_add = rsum + {8'h00, rx_byte};
  assign pidx_inc = pidx + LEN_W'(1);
  assign wr_idx   = pidx;
  assign wr_data  = rx_byte;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_SYNC;
      dlen  <= '0;
      clen  <= '0;
      cmd   <= '0;
      pidx  <= '0;
      rsum  <= '0;
      ep    <= '0;
      sumh  <= '0;
    end else begin
      state <= state_next;
      dlen  <= dlen_next;
      clen  <= clen_next;
      cmd   <= cmd_next;
      pidx  <= pidx_next;
      rsum  <= rsum_next;
      ep    <= ep_next;
      sumh  <= sumh_next;
    end
  end

  // Frame parser.
  always_comb begin
    state_next = state;
    dlen_next  = dlen;
    clen_next  = clen;
    cmd_next   = cmd;
    pidx_next  = pidx;
    rsum_next  = rsum;
    ep_next    = ep;
    sumh_next  = sumh;
    push       = 1'b0;
    wr_en      = 1'b0;
    if (acc) begin
      unique case (state)
        P_SYNC: begin
          if (rx_byte == SYNC_BYTE) begin
            rsum_next  = SUM_SEED;
            state_next = P_DLEN;
          end
        end
        P_DLEN: begin
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            state_next = P_SYNC;
          end else begin
            dlen_next  = rx_byte[LEN_W-1:0];
            rsum_next  = rsum_add;
            state_next = P_CLEN;
          end
        end
        P_CLEN: begin
          if (rx_byte > {{(8-LEN_W){1'b0}}, dlen}) begin
            state_next = P_SYNC;
          end else begin
            clen_next  = rx_byte[LEN_W-1:0];
            pidx_next  = '0;
            rsum_next  = rsum_add;
            state_next = P_CMD;
          end
        end
        P_CMD: begin
          cmd_next   = rx_byte;
          rsum_next  = rsum_add;
          state_next = (dlen == '0) ? P_EPH : P_PAY;
        end
        P_PAY: begin
          wr_en     = 1'b1;
          pidx_next = pidx_inc;
          rsum_next = rsum_add;
          if (pidx_inc >= dlen) begin
            state_next = P_EPH;
          end
        end
        P_EPH: begin
          ep_next    = {rx_byte, 8'h00};
          rsum_next  = rsum_add;
          state_next = P_EPL;
        end
        P_EPL: begin
          ep_next    = {ep[15:8], rx_byte};
          rsum_next  = rsum_add;
          state_next = P_SUMH;
        end
        P_SUMH: begin
          sumh_next  = rx_byte;
          state_next = P_SUML;
        end
        P_SUML: begin
          push       = ({sumh, rx_byte} == rsum);
          state_next = P_SYNC;
        end
        default: begin
          state_next = P_SYNC;
        end
      endcase
    end
  end

  // Frame classification for the descriptor.
  always_comb begin
    push_desc     = '0;
    push_desc.cmd = cmd;
    push_desc.dlen = dlen;
    pix_pos       = 16'h0000;
    if (ep == BCAST_EP) begin
      push_desc.route    = ROUTE_BCAST;
      push_desc.cmd_out  = cmd;
      push_desc.clen_out = clen;
      push_desc.endp_out = ep;
    end else if (ep == LOCAL_EP) begin
      push_desc.route    = ROUTE_LOCAL;
      push_desc.cmd_out  = NODE_TX_CMD;
      push_desc.clen_out = '0;
      push_desc.endp_out = NODE_TX_EP;
    end else begin
      push_desc.route    = ROUTE_PASS;
      push_desc.cmd_out  = cmd;
      push_desc.clen_out = clen;
      push_desc.endp_out = ep - 16'd1;
      pix_pos            = ep;
    end
    // The pixel bit exists only for pixel commands and inside the payload.
    pix_cmd            = (cmd == PIXEL_CMD) || (cmd == PIXEL_CMD_LUT);
    pix_byte           = pix_pos[15:3];
    push_desc.pix_en   = pix_cmd && (pix_byte < {{(13-LEN_W){1'b0}}, dlen});
    push_desc.pix_addr = pix_byte[LEN_W-1:0];
    push_desc.pix_sel  = pix_pos[2:0];
  end

endmodule

// File: design/dcfr_buffer.sv
// ----------------------------------------------------------------------------
// dcfr_buffer: frame queue between parser and sender
// Two descriptor slots, each owning one bank of the payload memory. A bank
// is written only while its slot is free and read until the slot is popped.
// ----------------------------------------------------------------------------
module dcfr_buffer #(
  parameter int MAX_PAYLOAD = dcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  dcfr_pkg::desc_t            push_desc,
  output logic                       full,
  input  logic                       pop,
  output logic                       empty,
  output dcfr_pkg::desc_t            head,
  input  logic                       wr_en,
  input  logic [dcfr_pkg::LEN_W-1:0] wr_idx,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [dcfr_pkg::LEN_W-1:0] rd_idx,
  output logic [7:0]                 rd_data
);
  import dcfr_pkg::*;

  localparam int MEM_D  = 2 * MAX_PAYLOAD;
  localparam int ADDR_W = $clog2(MEM_D);

  desc_t             slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic [7:0]        mem [MEM_D];
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  // Bank base follows the slot that owns the frame.
  assign waddr = wr_ptr ? ADDR_W'(MAX_PAYLOAD) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
  assign raddr = rd_ptr ? ADDR_W'(MAX_PAYLOAD) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

  // Descriptor queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_desc;
    end
  end

  // Payload memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

// File: design/dcfr_back.sv
// ----------------------------------------------------------------------------
// dcfr_back: transmit sender
// Rebuilds the outgoing frame from the head descriptor and its payload
// bank, recomputes the checksum and drives the output register.
// ----------------------------------------------------------------------------
module dcfr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  dcfr_pkg::desc_t            head,
  output logic                       pop,
  output logic                       rd_en,
  output logic [dcfr_pkg::LEN_W-1:0] rd_idx,
  input  logic [7:0]                 rd_data,
  output logic                       tx_valid,
  input  logic                       tx_ready,
  output logic [7:0]                 tx_byte,
  output logic                       last_byte,
  output logic [1:0]                 route,
  output logic [7:0]                 command_code,
  output logic                       pixel_bit
);
  import dcfr_pkg::*;

  b_state_t         state, state_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [15:0]      sum, sum_next;
  logic             pix, pix_next;
  logic             out_free;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic [LEN_W-1:0] idx_inc;

  assign out_free = !tx_valid || tx_ready;
  assign idx_inc  = idx + LEN_W'(1);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
      sum   <= '0;
      pix   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      sum   <= sum_next;
      pix   <= pix_next;
    end
  end

  // Output register: a new byte is loaded when the slot is empty or taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (load) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte      <= load_byte;
      last_byte    <= load_last;
      route        <= head.route;
      command_code <= head.cmd;
      pixel_bit    <= pix;
    end
  end

  // Frame sequencer.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    sum_next   = sum;
    pix_next   = pix;
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = idx;
    load       = 1'b0;
    load_byte  = 8'h00;
    load_last  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          rd_en      = 1'b1;
          rd_idx     = head.pix_addr;
          state_next = B_PIX;
        end
      end
      B_PIX: begin
        pix_next   = head.pix_en && rd_data[head.pix_sel];
        state_next = B_SYNC;
      end
      B_SYNC: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = SYNC_BYTE;
          sum_next   = SUM_SEED;
          state_next = B_DLEN;
        end
      end
      B_DLEN: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = {{(8-LEN_W){1'b0}}, head.dlen};
          sum_next   = sum + {8'h00, load_byte};
          state_next = B_CLEN;
        end
      end
      B_CLEN: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = {{(8-LEN_W){1'b0}}, head.clen_out};
          sum_next   = sum + {8'h00, load_byte};
          state_next = B_CMD;
        end
      end
      B_CMD: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = head.cmd_out;
          sum_next   = sum + {8'h00, load_byte};
          idx_next   = '0;
          state_next = (head.dlen == '0) ? B_EPH : B_PRD;
        end
      end
      B_PRD: begin
        // Fetch the payload byte; bytes past the command length are zero.
        rd_en      = (idx < head.clen_out);
        state_next = B_PDAT;
      end
      B_PDAT: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = (idx < head.clen_out) ? rd_data : 8'h00;
          sum_next   = sum + {8'h00, load_byte};
          idx_next   = idx_inc;
          state_next = (idx_inc == head.dlen) ? B_EPH : B_PRD;
        end
      end
      B_EPH: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = head.endp_out[15:8];
          sum_next   = sum + {8'h00, load_byte};
          state_next = B_EPL;
        end
      end
      B_EPL: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = head.endp_out[7:0];
          sum_next   = sum + {8'h00, load_byte};
          state_next = B_SUMH;
        end
      end
      B_SUMH: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = sum[15:8];
          state_next = B_SUML;
        end
      end
      B_SUML: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = sum[7:0];
          load_last  = 1'b1;
          pop        = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the daisy-chain frame repeater
// Feeds link bytes into the repeater: a few hand-built frames first, then
// random good, corrupt, malformed and truncated frames mixed with line noise.
// Both sides stall at random. Every transmitted byte is checked against a
// frame-level prediction of the outgoing frame.
// ----------------------------------------------------------------------------
module testbench;
  import dcfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_BYTES = 130;

  // One byte request on the receive side; drain_first holds it back until
  // every predicted outgoing byte has been seen.
  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } rx_req_t;

  // One outgoing byte with its side fields.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] route;
    logic [7:0] cmd;
    logic       pix;
  } tx_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       tx_valid;
  logic       tx_ready = 1'b0;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [1:0] route;
  logic [7:0] command_code;
  logic       pixel_bit;

  rx_req_t  rx_pending[$];
  tx_beat_t repeated_bytes[$];
  bit       rx_taken = 1'b0;
  int       rx_wait = 0;
  int       rx_calm = 0;
  int       tx_hold = 0;
  int       tx_calm = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  // Mirror of the receive parser.
  p_state_t    parse_at = P_SYNC;
  logic [5:0]  rx_dlen = '0;
  logic [5:0]  rx_clen = '0;
  logic [5:0]  rx_pidx = '0;
  logic [7:0]  rx_cmd = '0;
  logic [7:0]  rx_sum_hi = '0;
  logic [15:0] rx_sum = '0;
  logic [15:0] rx_ep = '0;
  logic [7:0]  rx_payload [MAX_PAYLOAD_DEF];

  daisy_chain_frame_repeater_unit dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .tx_valid     (tx_valid),
    .tx_ready     (tx_ready),
    .tx_byte      (tx_byte),
    .last_byte    (last_byte),
    .route        (route),
    .command_code (command_code),
    .pixel_bit    (pixel_bit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // Gap lengths: mostly none, some short, a few long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds the frame the repeater must send for the frame just checked.
  task automatic queue_repeated_frame();
    logic [1:0]  rt;
    logic [7:0]  cmd_o;
    logic [5:0]  clen_o;
    logic [15:0] ep_o;
    logic [15:0] pix_at;
    logic [15:0] csum;
    logic        pix;
    logic [7:0]  fb[$];
    tx_beat_t    beat;
    pix_at = 16'h0000;
    if (rx_ep == BCAST_EP) begin
      rt = ROUTE_BCAST;
      cmd_o = rx_cmd;
      clen_o = rx_clen;
      ep_o = rx_ep;
    end else if (rx_ep == LOCAL_EP) begin
      rt = ROUTE_LOCAL;
      cmd_o = NODE_TX_CMD;
      clen_o = '0;
      ep_o = NODE_TX_EP;
    end else begin
      rt = ROUTE_PASS;
      cmd_o = rx_cmd;
      clen_o = rx_clen;
      ep_o = rx_ep - 16'd1;
      pix_at = rx_ep;
    end
    // The pixel bit reads as zero once its byte lies past the payload.
    pix = 1'b0;
    if ((rx_cmd == PIXEL_CMD || rx_cmd == PIXEL_CMD_LUT) && (pix_at >> 3) < rx_dlen) begin
      pix = rx_payload[pix_at >> 3][pix_at[2:0]];
    end
    fb.push_back(SYNC_BYTE);
    fb.push_back({2'b00, rx_dlen});
    fb.push_back({2'b00, clen_o});
    fb.push_back(cmd_o);
    for (int i = 0; i < rx_dlen; i++) begin
      fb.push_back((i < clen_o) ? rx_payload[i] : 8'h00);
    end
    fb.push_back(ep_o[15:8]);
    fb.push_back(ep_o[7:0]);
    // The seed stands in for the sync byte, so the sum starts after it.
    csum = SUM_SEED;
    for (int i = 1; i < fb.size(); i++) begin
      csum = csum + fb[i];
    end
    fb.push_back(csum[15:8]);
    fb.push_back(csum[7:0]);
    for (int i = 0; i < fb.size(); i++) begin
      beat.data = fb[i];
      beat.last = (i == fb.size() - 1);
      beat.route = rt;
      beat.cmd = rx_cmd;
      beat.pix = pix;
      repeated_bytes.push_back(beat);
    end
  endtask

  // Advances the parser mirror by one received byte.
  task automatic track_rx_byte(input logic [7:0] b);
    case (parse_at)
      P_SYNC: begin
        if (b == SYNC_BYTE) begin
          rx_sum = SUM_SEED;
          parse_at = P_DLEN;
        end
      end
      P_DLEN: begin
        if (b > MAX_PAYLOAD_DEF) begin
          parse_at = P_SYNC;
        end else begin
          rx_dlen = b[5:0];
          rx_sum = rx_sum + b;
          parse_at = P_CLEN;
        end
      end
      P_CLEN: begin
        if (b > rx_dlen) begin
          parse_at = P_SYNC;
        end else begin
          rx_clen = b[5:0];
          rx_pidx = '0;
          rx_sum = rx_sum + b;
          parse_at = P_CMD;
        end
      end
      P_CMD: begin
        rx_cmd = b;
        rx_sum = rx_sum + b;
        if (rx_dlen == 0) begin
          parse_at = P_EPH;
        end else begin
          parse_at = P_PAY;
        end
      end
      P_PAY: begin
        if (rx_pidx < MAX_PAYLOAD_DEF) begin
          rx_payload[rx_pidx] = b;
        end
        rx_pidx = rx_pidx + 6'd1;
        rx_sum = rx_sum + b;
        if (rx_pidx >= rx_dlen) begin
          parse_at = P_EPH;
        end
      end
      P_EPH: begin
        rx_ep = {b, 8'h00};
        rx_sum = rx_sum + b;
        parse_at = P_EPL;
      end
      P_EPL: begin
        rx_ep[7:0] = b;
        rx_sum = rx_sum + b;
        parse_at = P_SUMH;
      end
      P_SUMH: begin
        rx_sum_hi = b;
        parse_at = P_SUML;
      end
      P_SUML: begin
        if ({rx_sum_hi, b} == rx_sum) begin
          queue_repeated_frame();
        end
        parse_at = P_SYNC;
      end
      default: begin
        parse_at = P_SYNC;
      end
    endcase
  endtask

  task automatic push_rx(input logic [7:0] b, input bit drain);
    rx_req_t r;
    r.data = b;
    r.drain_first = drain;
    rx_pending.push_back(r);
  endtask

  // Queues a complete frame with random payload; corrupt spoils the checksum.
  task automatic add_frame(input int dlen, input int clen, input logic [7:0] cmd,
                           input logic [15:0] ep, input bit corrupt, input bit drain);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = SUM_SEED + 16'(dlen) + 16'(clen) + cmd;
    push_rx(SYNC_BYTE, drain);
    push_rx(8'(dlen), 1'b0);
    push_rx(8'(clen), 1'b0);
    push_rx(cmd, 1'b0);
    for (int i = 0; i < dlen; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      push_rx(b, 1'b0);
    end
    sum = sum + ep[15:8];
    sum = sum + ep[7:0];
    if (corrupt) begin
      sum = sum ^ 16'($urandom_range(1, 65535));
    end
    push_rx(ep[15:8], 1'b0);
    push_rx(ep[7:0], 1'b0);
    push_rx(sum[15:8], 1'b0);
    push_rx(sum[7:0], 1'b0);
  endtask

  // Well-formed frame with random sizes, command and endpoint; one in ten has a spoiled checksum.
  task automatic add_random_frame(input bit drain);
    int          dlen;
    int          clen;
    logic [7:0]  cmd;
    logic [15:0] ep;
    if ($urandom_range(0, 19) == 0) begin
      dlen = $urandom_range(9, MAX_PAYLOAD_DEF);
    end else begin
      dlen = $urandom_range(0, 8);
    end
    clen = $urandom_range(0, dlen);
    case ($urandom_range(0, 3))
      0: cmd = PIXEL_CMD;
      1: cmd = PIXEL_CMD_LUT;
      2: cmd = NODE_TX_CMD;
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: ep = BCAST_EP;
      1: ep = LOCAL_EP;
      2: ep = NODE_TX_EP;
      3: ep = 16'($urandom_range(1, dlen * 8 + 15));
      4: ep = 16'($urandom_range(1, 2));
      default: ep = 16'($urandom);
    endcase
    add_frame(dlen, clen, cmd, ep, $urandom_range(0, 9) == 0, drain);
  endtask

  // Receive driver: presents the next request at the falling edge.
  always @(negedge clk) begin : rx_driver
    rx_req_t req;
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_taken) begin
      if (rx_wait != 0) begin
        rx_valid <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else if (rx_pending.size() == 0) begin
        rx_valid <= 1'b0;
      end else if (rx_pending[0].drain_first && repeated_bytes.size() != 0) begin
        rx_valid <= 1'b0;
      end else begin
        req = rx_pending.pop_front();
        rx_valid <= 1'b1;
        rx_byte <= req.data;
        rx_wait <= pick_gap(rx_calm);
      end
    end
  end

  // Transmit side back-pressure.
  always @(negedge clk) begin
    if (tx_hold != 0) begin
      tx_ready <= 1'b0;
      tx_hold <= tx_hold - 1;
    end else begin
      tx_ready <= 1'b1;
      tx_hold <= pick_gap(tx_calm);
    end
  end

  // Every accepted receive request advances the prediction.
  always @(posedge clk) begin
    rx_taken <= rx_valid && rx_ready && !rst;
    if (!rst && rx_valid && rx_ready) begin
      track_rx_byte(rx_byte);
    end
  end

  // Every accepted transmit byte is checked against the oldest prediction.
  always @(posedge clk) begin : tx_monitor
    tx_beat_t want;
    if (!rst && tx_valid && tx_ready) begin
      if (repeated_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %h last %b route %0d cmd %h pix %b",
                               tx_byte, last_byte, route, command_code, pixel_bit));
      end else begin
        want = repeated_bytes.pop_front();
        if (tx_byte !== want.data || last_byte !== want.last || route !== want.route ||
            command_code !== want.cmd || pixel_bit !== want.pix) begin
          note_failure($sformatf("byte/last/route/cmd/pix exp %h/%b/%0d/%h/%b got %h/%b/%0d/%h/%b",
                                 want.data, want.last, want.route, want.cmd, want.pix,
                                 tx_byte, last_byte, route, command_code, pixel_bit));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int         sent;
    int         sel;
    int         d;
    int         c;
    int         n;
    bit         mid_drain_done;
    logic [7:0] b;
    mid_drain_done = 1'b0;

    // Line noise while hunting for sync, at both byte extremes.
    push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0);
    // Empty broadcast; the pixel index falls past the empty payload.
    add_frame(0, 0, PIXEL_CMD, BCAST_EP, 1'b0, 1'b0);
    // Data length one above the buffer.
    push_rx(SYNC_BYTE, 1'b0);
    push_rx(8'(MAX_PAYLOAD_DEF + 1), 1'b0);
    // Command length longer than the data length.
    push_rx(SYNC_BYTE, 1'b0);
    push_rx(8'd1, 1'b0);
    push_rx(8'd2, 1'b0);
    // Local frame with a bad checksum is dropped.
    add_frame(0, 0, 8'h5A, LOCAL_EP, 1'b1, 1'b0);
    // Passing frame whose pixel bit comes from inside the payload.
    add_frame(1, 1, PIXEL_CMD, 16'd3, 1'b0, 1'b0);

    // Random part opens with a full buffer once the line has drained.
    add_frame(MAX_PAYLOAD_DEF, MAX_PAYLOAD_DEF, PIXEL_CMD_LUT,
              16'($urandom_range(8 * MAX_PAYLOAD_DEF - 8, 8 * MAX_PAYLOAD_DEF - 1)),
              1'b0, 1'b1);
    sent = rx_pending.size();
    while (sent < RANDOM_BYTES) begin
      if (!mid_drain_done && sent >= RANDOM_BYTES / 2) begin
        add_random_frame(1'b1);
        mid_drain_done = 1'b1;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          add_random_frame(1'b0);
        end else if (sel < 77) begin
          push_rx(SYNC_BYTE, 1'b0);
          push_rx(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 1'b0);
        end else if (sel < 84) begin
          d = $urandom_range(0, MAX_PAYLOAD_DEF - 1);
          push_rx(SYNC_BYTE, 1'b0);
          push_rx(8'(d), 1'b0);
          push_rx(8'($urandom_range(d + 1, 255)), 1'b0);
        end else if (sel < 91) begin
          // Truncated frame: the following bytes get swallowed by the parser.
          d = $urandom_range(0, 8);
          c = $urandom_range(0, d);
          push_rx(SYNC_BYTE, 1'b0);
          push_rx(8'(d), 1'b0);
          push_rx(8'(c), 1'b0);
          push_rx(8'($urandom), 1'b0);
          repeat ($urandom_range(0, d + 3)) push_rx(8'($urandom), 1'b0);
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            do begin
              b = 8'($urandom);
            end while (b == SYNC_BYTE);
            push_rx(b, 1'b0);
          end
        end
      end
      sent = rx_pending.size();
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_pending.size() != 0 || rx_valid) @(posedge clk);
    while (repeated_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
